// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the modem power supervisor checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define MPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define MPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mps_pkg.sv -----
// ---------------------------------------------------------------------------
// Modem power supervisor package
// Types, codes and constants shared by the supervisor and its checker.
// ---------------------------------------------------------------------------
`default_nettype none

package mps_pkg;

  // Default width of the seconds counter and all deadlines
  localparam int unsigned TIME_BITS_DEF = 32;

  // Fixed limits and timing constants
  localparam logic [7:0]  ERROR_LIMIT    = 8'd3;
  localparam logic [15:0] POLL_HOLD      = 16'd10;
  localparam int unsigned FIRST_DEADLINE = 15;
  localparam logic [15:0] BACKOFF_MAX    = 16'hFFFF;
  localparam logic [7:0]  FAIL_MAX       = 8'hFF;

  // Reported state codes
  localparam logic [2:0] SC_OFF    = 3'd0;
  localparam logic [2:0] SC_ON     = 3'd1;
  localparam logic [2:0] SC_INIT   = 3'd2;
  localparam logic [2:0] SC_NET_OK = 3'd3;
  localparam logic [2:0] SC_ERROR  = 3'd4;

  // Supervisor state, one-hot
  typedef enum logic [4:0] {
    ST_OFF    = 5'b00001,
    ST_ON     = 5'b00010,
    ST_INIT   = 5'b00100,
    ST_NET_OK = 5'b01000,
    ST_ERROR  = 5'b10000
  } st_e;

  // External command codes
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_ON    = 2'd1,
    CMD_OFF   = 2'd2,
    CMD_START = 2'd3
  } cmd_e;

  // Target state codes
  typedef enum logic [1:0] {
    TGT_OFF    = 2'd0,
    TGT_ON     = 2'd1,
    TGT_INIT   = 2'd2,
    TGT_NET_OK = 2'd3
  } tgt_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ON_SETTLE     = 3'd0,
    REG_ERROR_HOLD    = 3'd1,
    REG_INIT_TIMEOUT  = 3'd2,
    REG_INIT_TMO_ERR  = 3'd3,
    REG_HEALTH_PERIOD = 3'd4,
    REG_BACKOFF_STEP  = 3'd5,
    REG_FAILURE_HOLD  = 3'd6,
    REG_REQ_TIMEOUT   = 3'd7
  } reg_idx_e;

  // Configuration register file, seconds
  typedef struct packed {
    logic [15:0] on_settle;
    logic [15:0] error_hold;
    logic [15:0] init_timeout;
    logic [15:0] init_timeout_err;
    logic [15:0] health_period;
    logic [15:0] backoff_step;
    logic [15:0] failure_hold;
    logic [15:0] req_timeout;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    on_settle:        16'd1,
    error_hold:       16'd10,
    init_timeout:     16'd120,
    init_timeout_err: 16'd600,
    health_period:    16'd60,
    backoff_step:     16'd30,
    failure_hold:     16'd300,
    req_timeout:      16'd60
  };

  // Map a target code onto the state it names
  function automatic st_e tgt_to_state(tgt_e t);
    st_e s;
    case (t)
      TGT_OFF:    s = ST_OFF;
      TGT_ON:     s = ST_ON;
      TGT_INIT:   s = ST_INIT;
      TGT_NET_OK: s = ST_NET_OK;
      default:    s = ST_OFF;
    endcase
    return s;
  endfunction

  // Encode a one-hot state as its reported code
  function automatic logic [2:0] state_code(st_e s);
    logic [2:0] c;
    case (s)
      ST_OFF:    c = SC_OFF;
      ST_ON:     c = SC_ON;
      ST_INIT:   c = SC_INIT;
      ST_NET_OK: c = SC_NET_OK;
      ST_ERROR:  c = SC_ERROR;
      default:   c = SC_OFF;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/modem_power_supervisor_fsm.sv -----
// ---------------------------------------------------------------------------
// Modem power supervisor
// Tick-driven state machine that powers, starts, polls and checks a modem.
// ---------------------------------------------------------------------------
// Each accepted request is one one-second tick. The whole tick (target
// request, external command, state machine step and status check) is worked
// out in one pass of combinational logic from the state registers, and the
// result is loaded into an output register when the tick is accepted. A new tick
// can be accepted on every clock: the only thing that holds the input back is
// a result sitting in the output register while the downstream side stalls.
// Configuration writes are always taken (ready stays high) and should only be
// issued while no tick is in flight.
`default_nettype none

module modem_power_supervisor_fsm #(
  parameter int unsigned TIME_BITS = mps_pkg::TIME_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // Tick request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic        request_valid_i,
  input  wire logic [1:0]  requested_target_i,
  input  wire logic        start_ok_i,
  input  wire logic        poll_ok_i,
  input  wire logic        check_ok_i,
  input  wire logic        net_ready_i,
  // Result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       state_now_o,
  output logic [2:0]       reported_state_o,
  output logic             power_on_pulse_o,
  output logic             power_off_pulse_o,
  output logic             start_issued_o,
  output logic             poll_issued_o,
  output logic             check_issued_o,
  output logic             state_error_o,
  output logic             failure_hold_o
);
  import mps_pkg::*;

  typedef logic [TIME_BITS-1:0] tm_t;

  // Machine state touched by a state change
  typedef struct packed {
    st_e         st;
    tm_t         dl;
    logic [15:0] bo;
    logic [7:0]  fc;
    logic        ef;
  } sup_t;

  // Deadline a number of seconds from now, wrapping
  function automatic tm_t later(tm_t now, logic [15:0] secs);
    return now + TIME_BITS'(secs);
  endfunction

  // Enter a new state, loading its deadline and side effects
  function automatic sup_t enter_st(sup_t s, st_e ns, tm_t now, cfg_t c);
    sup_t        r;
    logic [16:0] bsum;
    r    = s;
    bsum = {1'b0, s.bo} + {1'b0, c.backoff_step};
    if (ns != s.st) begin
      case (ns)
        ST_OFF: begin
          r.dl = later(now, s.bo);
        end
        ST_ON: begin
          r.dl = later(now, c.on_settle);
        end
        ST_ERROR: begin
          r.bo = bsum[16] ? BACKOFF_MAX : bsum[15:0];
          r.dl = later(now, c.error_hold);
        end
        ST_INIT: begin
          r.dl = later(now, s.ef ? c.init_timeout_err : c.init_timeout);
        end
        default: begin
          r.bo = '0;
          r.fc = '0;
          r.dl = later(now, c.health_period);
        end
      endcase
      r.st = ns;
    end
    return r;
  endfunction

  // Registers
  cfg_t        cfg_q, cfg_d;
  tm_t         sec_q;
  sup_t        sup_q, sup_d;
  tgt_e        tgt_q, tgt_d;
  tm_t         prt_q, prt_d;
  tm_t         rdl_q, rdl_d;
  logic        out_valid_q, out_valid_d;

  // Result payload
  logic [2:0]  state_now_q, state_now_d;
  logic [2:0]  rep_q, rep_d;
  logic        p_on_q, p_off_q, p_start_q, p_poll_q, p_check_q, p_hold_q;
  logic        p_on_d, p_off_d, p_start_d, p_poll_d, p_check_d, p_hold_d;
  logic        state_err_q;

  logic        in_acc;
  logic        tgt_match;

  // Handshake
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;

  // Configuration write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_ON_SETTLE:     cfg_d.on_settle        = cfg_data_i;
        REG_ERROR_HOLD:    cfg_d.error_hold       = cfg_data_i;
        REG_INIT_TIMEOUT:  cfg_d.init_timeout     = cfg_data_i;
        REG_INIT_TMO_ERR:  cfg_d.init_timeout_err = cfg_data_i;
        REG_HEALTH_PERIOD: cfg_d.health_period    = cfg_data_i;
        REG_BACKOFF_STEP:  cfg_d.backoff_step     = cfg_data_i;
        REG_FAILURE_HOLD:  cfg_d.failure_hold     = cfg_data_i;
        REG_REQ_TIMEOUT:   cfg_d.req_timeout      = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  // One tick: request, command, machine step, status check
  always_comb begin
    sup_d     = sup_q;
    tgt_d     = tgt_q;
    prt_d     = prt_q;
    rdl_d     = rdl_q;
    p_on_d    = 1'b0;
    p_off_d   = 1'b0;
    p_start_d = 1'b0;
    p_poll_d  = 1'b0;
    p_check_d = 1'b0;
    p_hold_d  = 1'b0;

    // Take a new target; a changed target drops the current deadline
    if (request_valid_i) begin
      if (tgt_e'(requested_target_i) != tgt_q) begin
        sup_d.dl = '0;
      end
      tgt_d = tgt_e'(requested_target_i);
      rdl_d = later(sec_q, cfg_q.req_timeout);
    end

    // Execute the external command
    case (cmd_e'(cmd_i))
      CMD_ON: begin
        p_on_d = 1'b1;
        sup_d  = enter_st(sup_d, ST_ON, sec_q, cfg_q);
      end
      CMD_OFF: begin
        p_off_d = 1'b1;
        sup_d   = enter_st(sup_d, ST_OFF, sec_q, cfg_q);
      end
      CMD_START: begin
        p_start_d = 1'b1;
        sup_d = enter_st(sup_d, start_ok_i ? ST_INIT : ST_ERROR, sec_q, cfg_q);
      end
      default: ;
    endcase

    // Step the machine unless the poll hold is still running
    if (sec_q >= prt_q) begin
      case (sup_d.st)
        ST_OFF: begin
          if (sec_q >= sup_d.dl && tgt_d[1]) begin
            p_on_d = 1'b1;
            sup_d  = enter_st(sup_d, ST_ON, sec_q, cfg_q);
          end
        end
        ST_ON: begin
          if (sec_q >= sup_d.dl) begin
            p_start_d = 1'b1;
            sup_d = enter_st(sup_d, start_ok_i ? ST_INIT : ST_ERROR, sec_q, cfg_q);
          end
        end
        ST_ERROR: begin
          if (sec_q >= sup_d.dl) begin
            p_off_d = 1'b1;
            sup_d   = enter_st(sup_d, ST_OFF, sec_q, cfg_q);
            if (sup_d.fc >= ERROR_LIMIT) begin
              p_hold_d = 1'b1;
              sup_d.dl = later(sec_q, cfg_q.failure_hold);
            end
          end
        end
        ST_INIT: begin
          if (net_ready_i) begin
            sup_d = enter_st(sup_d, ST_NET_OK, sec_q, cfg_q);
          end else begin
            p_poll_d = 1'b1;
            if (!poll_ok_i) begin
              sup_d = enter_st(sup_d, ST_ERROR, sec_q, cfg_q);
            end else begin
              prt_d = later(sec_q, POLL_HOLD);
              if (sec_q > sup_d.dl) begin
                if (sup_d.fc != FAIL_MAX) begin
                  sup_d.fc = sup_d.fc + 8'd1;
                end
                sup_d = enter_st(sup_d, ST_ERROR, sec_q, cfg_q);
              end
            end
          end
        end
        ST_NET_OK: begin
          if (sec_q >= sup_d.dl) begin
            if (!net_ready_i) begin
              sup_d = enter_st(sup_d, ST_INIT, sec_q, cfg_q);
            end else begin
              p_check_d = 1'b1;
              if (!check_ok_i) begin
                sup_d = enter_st(sup_d, ST_ERROR, sec_q, cfg_q);
              end else begin
                sup_d.dl = later(sec_q, cfg_q.health_period);
              end
            end
          end
        end
        default: ;
      endcase
    end

    // Status check: clear the error flag on reaching the target, raise it late
    tgt_match = (tgt_to_state(tgt_d) == sup_d.st);
    if (tgt_match) begin
      if (sup_d.ef) begin
        sup_d.ef = 1'b0;
        sup_d.bo = '0;
      end
    end else if (!sup_d.ef && sec_q >= rdl_d) begin
      sup_d.ef = 1'b1;
    end

    state_now_d = state_code(sup_d.st);
    if (sup_d.ef) begin
      rep_d = SC_ERROR;
    end else if (tgt_match) begin
      rep_d = state_now_d;
    end else begin
      rep_d = SC_INIT;
    end
  end

  // Output valid: load on accept, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and machine state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_RESET;
      sec_q       <= '0;
      sup_q.st    <= ST_OFF;
      sup_q.dl    <= TIME_BITS'(FIRST_DEADLINE);
      sup_q.bo    <= '0;
      sup_q.fc    <= '0;
      sup_q.ef    <= 1'b0;
      tgt_q       <= TGT_OFF;
      prt_q       <= '0;
      rdl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        sec_q <= sec_q + tm_t'(1);
        sup_q <= sup_d;
        tgt_q <= tgt_d;
        prt_q <= prt_d;
        rdl_q <= rdl_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      state_now_q <= state_now_d;
      rep_q       <= rep_d;
      p_on_q      <= p_on_d;
      p_off_q     <= p_off_d;
      p_start_q   <= p_start_d;
      p_poll_q    <= p_poll_d;
      p_check_q   <= p_check_d;
      p_hold_q    <= p_hold_d;
      state_err_q <= sup_d.ef;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign state_now_o       = state_now_q;
  assign reported_state_o  = rep_q;
  assign power_on_pulse_o  = p_on_q;
  assign power_off_pulse_o = p_off_q;
  assign start_issued_o    = p_start_q;
  assign poll_issued_o     = p_poll_q;
  assign check_issued_o    = p_check_q;
  assign state_error_o     = state_err_q;
  assign failure_hold_o    = p_hold_q;

endmodule

`default_nettype wire

// ----- sv/mps_checker.sv -----
// ---------------------------------------------------------------------------
// Modem power supervisor checker
// Port-level checks on the supervisor, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mps_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [2:0] state_now_o,
  input wire logic [2:0] reported_state_o,
  input wire logic       power_off_pulse_o,
  input wire logic       state_error_o,
  input wire logic       failure_hold_o
);
  import mps_pkg::*;

  // A stalled result stays offered
  `MPS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(state_now_o), "stalled result dropped or changed")

  // Every accepted tick yields a result on the next cycle
  `MPS_ASSERT_NEXT(a_tick_result, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o, "accepted tick gave no result")

  // Reported error code tracks the error flag
  `MPS_ASSERT_NOW(a_rep_error, clk_i, rst_ni, out_valid_o, (reported_state_o == SC_ERROR) == state_error_o, "reported state disagrees with error flag")

  // Long off hold only comes with a power-off
  `MPS_ASSERT_NOW(a_hold_off, clk_i, rst_ni, out_valid_o && failure_hold_o, power_off_pulse_o, "failure hold without power off")

endmodule

bind modem_power_supervisor_fsm mps_checker u_mps_checker (.*);

`default_nettype wire

// ----- dv/supervisor_check_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modem power supervisor tracker
// Keeps its own copy of the supervisor state and register file, works out the
// status word that each accepted tick must produce and matches it against the
// status words that leave the block.
// ---------------------------------------------------------------------------

package supervisor_check_pkg;

  import mps_pkg::*;

  // One one-second tick as offered to the block
  typedef struct packed {
    cmd_e cmd;
    logic req_valid;
    tgt_e target;
    logic start_ok;
    logic poll_ok;
    logic check_ok;
    logic net_ready;
  } tick_t;

  // Status word returned for one tick
  typedef struct packed {
    logic [2:0] state_now;
    logic [2:0] reported;
    logic       power_on;
    logic       power_off;
    logic       start_sent;
    logic       poll_sent;
    logic       check_sent;
    logic       state_err;
    logic       hold_applied;
  } status_t;

  class supervisor_tracker;

    cfg_t        regs;
    logic [31:0] clock_secs;
    logic [2:0]  fsm;
    tgt_e        target;
    logic [31:0] deadline;
    logic [31:0] poll_resume;
    logic [31:0] req_deadline;
    logic [15:0] backoff;
    logic [7:0]  fail_cnt;
    logic        err_flag;
    logic        pon, poff, pstart, ppoll, pcheck, phold;
    status_t     expected_status[$];
    int          mismatches;

    function new();
      regs         = CFG_RESET;
      clock_secs   = '0;
      fsm          = SC_OFF;
      target       = TGT_OFF;
      deadline     = 32'(FIRST_DEADLINE);
      poll_resume  = '0;
      req_deadline = '0;
      backoff      = '0;
      fail_cnt     = '0;
      err_flag     = 1'b0;
      mismatches   = 0;
    endfunction

    function void set_register(reg_idx_e idx, logic [15:0] value);
      case (idx)
        REG_ON_SETTLE:     regs.on_settle        = value;
        REG_ERROR_HOLD:    regs.error_hold       = value;
        REG_INIT_TIMEOUT:  regs.init_timeout     = value;
        REG_INIT_TMO_ERR:  regs.init_timeout_err = value;
        REG_HEALTH_PERIOD: regs.health_period    = value;
        REG_BACKOFF_STEP:  regs.backoff_step     = value;
        REG_FAILURE_HOLD:  regs.failure_hold     = value;
        default:           regs.req_timeout      = value;
      endcase
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    // Move to a new state and arm its deadline; staying put keeps the deadline
    function void go_to(logic [2:0] next);
      logic [16:0] sum;
      if (next == fsm) return;
      case (next)
        SC_OFF: deadline = clock_secs + 32'(backoff);
        SC_ON:  deadline = clock_secs + 32'(regs.on_settle);
        SC_ERROR: begin
          // Grow the off-time backoff, saturating at 16 bits
          sum      = {1'b0, backoff} + {1'b0, regs.backoff_step};
          backoff  = sum[16] ? BACKOFF_MAX : sum[15:0];
          deadline = clock_secs + 32'(regs.error_hold);
        end
        SC_INIT: begin
          deadline = clock_secs +
                     32'(err_flag ? regs.init_timeout_err : regs.init_timeout);
        end
        default: begin
          backoff  = '0;
          fail_cnt = '0;
          deadline = clock_secs + 32'(regs.health_period);
        end
      endcase
      fsm = next;
    endfunction

    function void run_command(cmd_e c, logic start_ok);
      case (c)
        CMD_ON: begin
          pon = 1'b1;
          go_to(SC_ON);
        end
        CMD_OFF: begin
          poff = 1'b1;
          go_to(SC_OFF);
        end
        CMD_START: begin
          pstart = 1'b1;
          go_to(start_ok ? SC_INIT : SC_ERROR);
        end
        default: ;
      endcase
    endfunction

    // One step of the state machine, frozen while the poll hold runs
    function void step_fsm(tick_t t);
      if (clock_secs < poll_resume) return;
      case (fsm)
        SC_OFF: begin
          if (clock_secs >= deadline && (target == TGT_INIT || target == TGT_NET_OK))
            run_command(CMD_ON, 1'b0);
        end
        SC_ON: begin
          if (clock_secs >= deadline) run_command(CMD_START, t.start_ok);
        end
        SC_ERROR: begin
          if (clock_secs >= deadline) begin
            run_command(CMD_OFF, 1'b0);
            // Apply the long off hold once the failure limit is reached
            if (fail_cnt >= ERROR_LIMIT) begin
              phold    = 1'b1;
              deadline = clock_secs + 32'(regs.failure_hold);
            end
          end
        end
        SC_INIT: begin
          if (t.net_ready) begin
            go_to(SC_NET_OK);
          end else begin
            ppoll = 1'b1;
            if (!t.poll_ok) begin
              go_to(SC_ERROR);
            end else begin
              poll_resume = clock_secs + 32'(POLL_HOLD);
              if (clock_secs > deadline) begin
                if (fail_cnt != FAIL_MAX) fail_cnt = fail_cnt + 8'd1;
                go_to(SC_ERROR);
              end
            end
          end
        end
        default: begin
          if (clock_secs >= deadline) begin
            if (!t.net_ready) begin
              go_to(SC_INIT);
            end else begin
              pcheck = 1'b1;
              if (!t.check_ok) go_to(SC_ERROR);
              else deadline = clock_secs + 32'(regs.health_period);
            end
          end
        end
      endcase
    endfunction

    // Work out the status word of one accepted tick and queue it
    function void take_tick(tick_t t);
      status_t    s;
      logic [2:0] tgt_code;
      {pon, poff, pstart, ppoll, pcheck, phold} = '0;
      // Take the target request; a new target clears the state deadline
      if (t.req_valid) begin
        if (t.target != target) deadline = '0;
        target       = t.target;
        req_deadline = clock_secs + 32'(regs.req_timeout);
      end
      run_command(t.cmd, t.start_ok);
      step_fsm(t);
      // Raise or clear the sticky state error
      tgt_code = {1'b0, target};
      if (tgt_code == fsm) begin
        if (err_flag) begin
          err_flag = 1'b0;
          backoff  = '0;
        end
      end else if (!err_flag && clock_secs >= req_deadline) begin
        err_flag = 1'b1;
      end
      s.state_now    = fsm;
      s.reported     = err_flag ? SC_ERROR : ((tgt_code == fsm) ? fsm : SC_INIT);
      s.power_on     = pon;
      s.power_off    = poff;
      s.start_sent   = pstart;
      s.poll_sent    = ppoll;
      s.check_sent   = pcheck;
      s.state_err    = err_flag;
      s.hold_applied = phold;
      expected_status.push_back(s);
      clock_secs = clock_secs + 32'd1;
    endfunction

    function void compare(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Match one status word against the oldest expectation
    function void match_result(status_t got);
      status_t want;
      if (expected_status.size() == 0) begin
        mismatches++;
        $display("%0t: status word with no tick pending, state_now actual %0d",
                 $time, got.state_now);
        return;
      end
      want = expected_status.pop_front();
      compare("state_now", want.state_now, got.state_now);
      compare("reported_state", want.reported, got.reported);
      compare("power_on_pulse", 3'(want.power_on), 3'(got.power_on));
      compare("power_off_pulse", 3'(want.power_off), 3'(got.power_off));
      compare("start_issued", 3'(want.start_sent), 3'(got.start_sent));
      compare("poll_issued", 3'(want.poll_sent), 3'(got.poll_sent));
      compare("check_issued", 3'(want.check_sent), 3'(got.check_sent));
      compare("state_error", 3'(want.state_err), 3'(got.state_err));
      compare("failure_hold", 3'(want.hold_applied), 3'(got.hold_applied));
    endfunction

  endclass

endpackage

// ----- dv/tb_modem_power_supervisor_fsm.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modem power supervisor testbench
// Drives one-second ticks and register writes into the supervisor, with
// random gaps on the tick side and random stalls on the status side, and
// checks every status word against the tracker's own prediction.
// ---------------------------------------------------------------------------

module tb_modem_power_supervisor_fsm;

  import mps_pkg::*;
  import supervisor_check_pkg::*;

  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        cfg_valid_i        = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i        = '0;
  logic [15:0] cfg_data_i         = '0;
  logic        in_valid_i         = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i              = '0;
  logic        request_valid_i    = 1'b0;
  logic [1:0]  requested_target_i = '0;
  logic        start_ok_i         = 1'b0;
  logic        poll_ok_i          = 1'b0;
  logic        check_ok_i         = 1'b0;
  logic        net_ready_i        = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i        = 1'b0;
  logic [2:0]  state_now_o;
  logic [2:0]  reported_state_o;
  logic        power_on_pulse_o;
  logic        power_off_pulse_o;
  logic        start_issued_o;
  logic        poll_issued_o;
  logic        check_issued_o;
  logic        state_error_o;
  logic        failure_hold_o;

  supervisor_tracker tracker;
  status_t           seen;
  int                quiet_left = 0;
  logic              net_up     = 1'b0;

  modem_power_supervisor_fsm u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .request_valid_i    (request_valid_i),
    .requested_target_i (requested_target_i),
    .start_ok_i         (start_ok_i),
    .poll_ok_i          (poll_ok_i),
    .check_ok_i         (check_ok_i),
    .net_ready_i        (net_ready_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .state_now_o        (state_now_o),
    .reported_state_o   (reported_state_o),
    .power_on_pulse_o   (power_on_pulse_o),
    .power_off_pulse_o  (power_off_pulse_o),
    .start_issued_o     (start_issued_o),
    .poll_issued_o      (poll_issued_o),
    .check_issued_o     (check_issued_o),
    .state_error_o      (state_error_o),
    .failure_hold_o     (failure_hold_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop if the run hangs
  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic tick_t mk(cmd_e c, logic rv, tgt_e tg, logic s, logic p,
                               logic k, logic n);
    tick_t t;
    t.cmd       = c;
    t.req_valid = rv;
    t.target    = tg;
    t.start_ok  = s;
    t.poll_ok   = p;
    t.check_ok  = k;
    t.net_ready = n;
    return t;
  endfunction

  // Mostly plausible ticks, with some fully random noise mixed in
  function automatic tick_t make_tick();
    tick_t t;
    if ($urandom_range(0, 99) < 15) begin
      t = tick_t'($urandom);
      return t;
    end
    if ($urandom_range(0, 99) < 8) net_up = ~net_up;
    t.cmd       = ($urandom_range(0, 99) < 92) ? CMD_NONE : cmd_e'($urandom_range(1, 3));
    t.req_valid = ($urandom_range(0, 99) < 4);
    t.target    = ($urandom_range(0, 99) < 60) ? TGT_NET_OK : tgt_e'($urandom_range(0, 3));
    t.start_ok  = ($urandom_range(0, 99) < 90);
    t.poll_ok   = ($urandom_range(0, 99) < 90);
    t.check_ok  = ($urandom_range(0, 99) < 92);
    t.net_ready = net_up;
    return t;
  endfunction

  // Register set with each field at an extreme or a short time
  function automatic cfg_t random_cfg();
    cfg_t        c;
    int unsigned r;
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(0, 99);
      c[127 - 16*i -: 16] = (r < 10) ? 16'd0 : (r < 18) ? 16'hFFFF :
                            16'($urandom_range(0, 40));
    end
    return c;
  endfunction

  // Tick-side gap: mostly none or short, a few long, with idle-free stretches
  function automatic int pick_gap();
    int unsigned r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one tick and hold it until accepted
  task automatic send_tick(input tick_t t);
    logic taken;
    in_valid_i         <= 1'b1;
    cmd_i              <= t.cmd;
    request_valid_i    <= t.req_valid;
    requested_target_i <= t.target;
    start_ok_i         <= t.start_ok;
    poll_ok_i          <= t.poll_ok;
    check_ok_i         <= t.check_ok;
    net_ready_i        <= t.net_ready;
    do begin
      @(negedge clk_i);
      taken = (in_stall_o === 1'b0);
      @(posedge clk_i);
    end while (!taken);
    tracker.take_tick(t);
  endtask

  task automatic play(input tick_t t);
    int n;
    n = pick_gap();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    send_tick(t);
  endtask

  task automatic random_run(input int n);
    repeat (n) play(make_tick());
  endtask

  // Drop valid and wait until every status word has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Write all eight registers while the block is idle
  task automatic load_settings(input cfg_t c);
    logic taken;
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_idx_e'(i);
      cfg_data_i  <= c[127 - 16*i -: 16];
      do begin
        @(negedge clk_i);
        taken = (cfg_ready_o === 1'b1);
        @(posedge clk_i);
      end while (!taken);
      tracker.set_register(reg_idx_e'(i), c[127 - 16*i -: 16]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic phase(input cfg_t c, input int n);
    drain();
    load_settings(c);
    random_run(n);
  endtask

  // Status-side stalls: short bursts, a few long, with long free stretches
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      repeat (($urandom_range(0, 99) < 15) ? $urandom_range(40, 200) :
              $urandom_range(1, 8)) @(posedge clk_i);
      out_stall_i <= 1'b1;
      repeat (($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) :
              $urandom_range(10, 40)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // Check each status word just before the edge that takes it
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      seen.state_now    = state_now_o;
      seen.reported     = reported_state_o;
      seen.power_on     = power_on_pulse_o;
      seen.power_off    = power_off_pulse_o;
      seen.start_sent   = start_issued_o;
      seen.poll_sent    = poll_issued_o;
      seen.check_sent   = check_issued_o;
      seen.state_err    = state_error_o;
      seen.hold_applied = failure_hold_o;
      tracker.match_result(seen);
    end
  end

  initial begin
    tracker = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed ticks at reset settings
    play(mk(CMD_NONE,  0, TGT_OFF,    0, 0, 0, 0));
    play(mk(CMD_NONE,  1, TGT_ON,     0, 0, 0, 0));   // target on: stay off
    play(mk(CMD_NONE,  0, TGT_OFF,    1, 1, 1, 1));
    play(mk(CMD_ON,    0, TGT_OFF,    0, 0, 0, 0));
    play(mk(CMD_ON,    0, TGT_OFF,    1, 0, 1, 0));   // repeated power on
    play(mk(CMD_START, 0, TGT_OFF,    0, 1, 1, 1));   // start fails
    play(mk(CMD_START, 0, TGT_OFF,    0, 1, 1, 1));
    play(mk(CMD_START, 1, TGT_INIT,   1, 1, 0, 0));   // start, poll, hold
    play(mk(CMD_NONE,  0, TGT_INIT,   0, 0, 0, 1));
    play(mk(CMD_OFF,   1, TGT_NET_OK, 0, 0, 0, 0));
    play(mk(CMD_OFF,   0, TGT_NET_OK, 1, 1, 1, 1));   // repeated power off
    play(mk(CMD_START, 1, TGT_NET_OK, 1, 1, 1, 1));
    play(mk(CMD_NONE,  0, TGT_OFF,    0, 1, 0, 1));
    play(mk(CMD_START, 1, TGT_OFF,    1, 0, 0, 0));
    play(mk(CMD_ON,    1, TGT_ON,     1, 1, 1, 0));
    play(mk(CMD_START, 0, TGT_OFF,    1, 0, 1, 0));
    for (int i = 0; i < 8; i++) play(mk(CMD_NONE, 0, TGT_OFF, 1, 1, 1, i[0]));
    random_run(300);

    // Short times, then every register at its maximum and at zero
    phase('{16'd0, 16'd2, 16'd5, 16'd12, 16'd3, 16'd4, 16'd8, 16'd6}, 300);
    phase(cfg_t'('1), 150);
    phase(cfg_t'('0), 250);

    // Fail registration past the counter limit, restarting by command,
    // then let the machine cycle on its own so the off hold shows
    play(mk(CMD_START, 1, TGT_NET_OK, 1, 1, 1, 0));
    repeat (120) play(mk(CMD_START, 0, TGT_NET_OK, 1, 1, 1, 0));
    repeat (200) play(mk(CMD_NONE, 0, TGT_NET_OK, 1, 1, 1, 0));

    // Random register sets
    repeat (5) phase(random_cfg(), 120);

    drain();
    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
